// ===== design/glyph_alpha_blend_clip_assert.svh =====
// Assertion macros shared by the glyph blender RTL.
// Depends on clk_i and rst_ni being visible in the including module.
`ifndef GLYPH_ALPHA_BLEND_CLIP_ASSERT_SVH
`define GLYPH_ALPHA_BLEND_CLIP_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define GABC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("glyph blender assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define GABC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("glyph blender assertion failed");

`endif

// ===== design/gabc_pkg.sv =====
// Package for the glyph alpha blender: beat types, register map and constants.
// Used by gabc_lane and glyph_alpha_blend_clip; depends on nothing.
`timescale 1ns / 1ps

package gabc_pkg;

  localparam int unsigned ChanW    = 8;
  localparam int unsigned CoordW   = 16;
  localparam int unsigned FbDimW   = 14;
  localparam int unsigned AddrW    = 5;
  localparam int unsigned DataW    = 32;

  localparam logic [ChanW-1:0] CovFull  = 8'hff;
  localparam logic [ChanW-1:0] CovNone  = 8'h00;
  localparam logic [ChanW-1:0] AlphaOut = 8'hff;
  localparam int unsigned      RoundAdd = 127;
  // 2^23 / 255 rounded up; exact floor division for dividends below 66052.
  localparam int unsigned      RecipMul = 32897;
  localparam int unsigned      RecipSh  = 23;

  typedef enum logic [2:0] {
    RegClipLeft   = 3'd0,
    RegClipTop    = 3'd1,
    RegClipRight  = 3'd2,
    RegClipBottom = 3'd3,
    RegFbWidth    = 3'd4,
    RegFbHeight   = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic signed [CoordW-1:0] pixel_x;
    logic signed [CoordW-1:0] pixel_y;
    logic [ChanW-1:0]         coverage;
    logic [3*ChanW-1:0]       dest_rgb;
    logic [3*ChanW-1:0]       ink_rgb;
  } pix_in_t;

  typedef struct packed {
    logic        write_enable;
    logic [31:0] pixel_out;
  } pix_out_t;

endpackage

// ===== design/gabc_lane.sv =====
// One color channel of the blender: product stage and divide-by-255 stage.
// Depends on gabc_pkg for widths and the reciprocal constant.
`timescale 1ns / 1ps

module gabc_lane import gabc_pkg::*; (
  input  logic             clk_i,
  input  logic             load_i,
  input  logic [ChanW-1:0] ca_i,
  input  logic [ChanW-1:0] cb_i,
  input  logic [ChanW-1:0] t_i,
  output logic [ChanW-1:0] c_o
);

  logic signed [ChanW:0]   diff;
  logic signed [17:0]      prod;
  logic signed [17:0]      p_d, p_q;
  logic [ChanW-1:0]        ca_q;
  logic [16:0]             mag;
  logic [33:0]             scaled;
  logic [ChanW-1:0]        quot;
  logic signed [ChanW+1:0] sum;

  // Stage one: signed difference times coverage, plus the rounding term.
  assign diff = $signed({1'b0, cb_i}) - $signed({1'b0, ca_i});
  assign prod = diff * $signed({1'b0, t_i});
  assign p_d  = prod + 18'(RoundAdd);

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      p_q  <= p_d;
      ca_q <= ca_i;
    end
  end

  // Stage two: divide the magnitude by 255 and restore the sign, which
  // truncates toward zero, then add to the destination channel and clamp.
  assign mag    = p_q[17] ? 17'(-p_q) : 17'(p_q);
  assign scaled = 34'(mag) * 34'(RecipMul);
  assign quot   = scaled[RecipSh +: ChanW];

  always_comb begin
    if (p_q[17]) begin
      sum = $signed({2'b00, ca_q}) - $signed({2'b00, quot});
    end else begin
      sum = $signed({2'b00, ca_q}) + $signed({2'b00, quot});
    end
    if (sum < 0) begin
      c_o = '0;
    end else if (sum > 10'sd255) begin
      c_o = '1;
    end else begin
      c_o = sum[ChanW-1:0];
    end
  end

endmodule

// ===== design/glyph_alpha_blend_clip.sv =====
// Top level of the glyph alpha blender: APB registers, clip test and pipeline.
// Depends on gabc_pkg, gabc_lane and glyph_alpha_blend_clip_assert.svh.
//
//   Channel   Direction  Handshake                    Beat
//   pixel in  input      in_valid_i / in_stall_o      pix_in_t
//   pixel out output     out_valid_o / out_stall_i    pix_out_t
//   config    input      psel/penable/pwrite/pready   32-bit register
//
// The block takes one pixel beat per clock while the output is not stalled
// and passes it through an input register, a product register and the
// result register. The per-channel multiplier and the divide-by-255 by
// reciprocal each own one of the two compute stages. Each stage advances
// when it is empty or the stage after it advances, so a stalled output
// fills the pipeline before the input side stalls. Reset clears every
// valid bit and all six registers to zero, which makes the clip region
// empty.
`timescale 1ns / 1ps
`include "glyph_alpha_blend_clip_assert.svh"

module glyph_alpha_blend_clip import gabc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  pix_in_t          in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output pix_out_t         out_data_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  // Configuration registers.
  logic signed [CoordW-1:0] clip_left_q, clip_top_q, clip_right_q, clip_bottom_q;
  logic [FbDimW-1:0]        fb_width_q, fb_height_q;
  logic                     cfg_wr;
  reg_idx_e                 cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_e'(paddr[AddrW-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_left_q   <= '0;
      clip_top_q    <= '0;
      clip_right_q  <= '0;
      clip_bottom_q <= '0;
      fb_width_q    <= '0;
      fb_height_q   <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        RegClipLeft:   clip_left_q   <= pwdata[CoordW-1:0];
        RegClipTop:    clip_top_q    <= pwdata[CoordW-1:0];
        RegClipRight:  clip_right_q  <= pwdata[CoordW-1:0];
        RegClipBottom: clip_bottom_q <= pwdata[CoordW-1:0];
        RegFbWidth:    fb_width_q    <= pwdata[FbDimW-1:0];
        RegFbHeight:   fb_height_q   <= pwdata[FbDimW-1:0];
        default: ;
      endcase
    end
  end

  // Reads return the stored value, with the signed edges sign extended.
  always_comb begin
    case (cfg_idx)
      RegClipLeft:   prdata = DataW'(clip_left_q);
      RegClipTop:    prdata = DataW'(clip_top_q);
      RegClipRight:  prdata = DataW'(clip_right_q);
      RegClipBottom: prdata = DataW'(clip_bottom_q);
      RegFbWidth:    prdata = DataW'(fb_width_q);
      RegFbHeight:   prdata = DataW'(fb_height_q);
      default:       prdata = '0;
    endcase
  end

  // Pipeline flow control.
  logic s0_valid_q, s1_valid_q, out_valid_q;
  logic adv0, adv1, adv_out;

  assign adv_out    = !out_valid_q || !out_stall_i;
  assign adv1       = !s1_valid_q || adv_out;
  assign adv0       = !s0_valid_q || adv1;
  assign in_stall_o = !adv0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q  <= 1'b0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv0) begin
        s0_valid_q <= in_valid_i;
      end
      if (adv1) begin
        s1_valid_q <= s0_valid_q;
      end
      if (adv_out) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // Input register.
  pix_in_t s0_q;

  always_ff @(posedge clk_i) begin
    if (adv0 && in_valid_i) begin
      s0_q <= in_data_i;
    end
  end

  // Clip rectangle intersected with the framebuffer, compared at 17 bits so
  // that the framebuffer size and the signed edges share one signed range.
  logic signed [CoordW:0] x0, y0, x1, y1, px, py, cr, cb, fw, fh;
  logic                   inside_d;

  always_comb begin
    px = {s0_q.pixel_x[CoordW-1], s0_q.pixel_x};
    py = {s0_q.pixel_y[CoordW-1], s0_q.pixel_y};
    x0 = clip_left_q[CoordW-1] ? '0 : {1'b0, clip_left_q};
    y0 = clip_top_q[CoordW-1]  ? '0 : {1'b0, clip_top_q};
    cr = {clip_right_q[CoordW-1], clip_right_q};
    cb = {clip_bottom_q[CoordW-1], clip_bottom_q};
    fw = $signed({3'b000, fb_width_q});
    fh = $signed({3'b000, fb_height_q});
    x1 = (cr > fw) ? fw : cr;
    y1 = (cb > fh) ? fh : cb;
    inside_d = (px >= x0) && (px < x1) && (py >= y0) && (py < y1);
  end

  // Second stage: clip verdict, coverage class and the ink color.
  logic               s1_inside_q, s1_cov_nz_q, s1_cov_full_q;
  logic [3*ChanW-1:0] s1_ink_q;

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      s1_inside_q   <= inside_d;
      s1_cov_nz_q   <= (s0_q.coverage != CovNone);
      s1_cov_full_q <= (s0_q.coverage == CovFull);
      s1_ink_q      <= s0_q.ink_rgb;
    end
  end

  // Channel lanes, blue in the low byte.
  logic [3*ChanW-1:0] blend_rgb;

  for (genvar g = 0; g < 3; g++) begin : g_lane
    gabc_lane u_lane (
      .clk_i  (clk_i),
      .load_i (adv1),
      .ca_i   (s0_q.dest_rgb[g*ChanW +: ChanW]),
      .cb_i   (s0_q.ink_rgb[g*ChanW +: ChanW]),
      .t_i    (s0_q.coverage),
      .c_o    (blend_rgb[g*ChanW +: ChanW])
    );
  end

  // Result register. A pixel that is not written carries zero.
  pix_out_t out_d, out_data_q;

  always_comb begin
    out_d.write_enable = s1_inside_q && s1_cov_nz_q;
    if (out_d.write_enable) begin
      out_d.pixel_out = {AlphaOut, s1_cov_full_q ? s1_ink_q : blend_rgb};
    end else begin
      out_d.pixel_out = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_out) begin
      out_data_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // A skipped pixel never carries color, and a written one is opaque.
  `GABC_ASSERT_NOW(a_skip_zero, out_valid_q && !out_data_q.write_enable,
                   out_data_q.pixel_out == '0)
  `GABC_ASSERT_NOW(a_write_opaque, out_valid_q && out_data_q.write_enable,
                   out_data_q.pixel_out[31:24] == AlphaOut)
  // The input side only stalls when every stage holds a beat.
  `GABC_ASSERT_NOW(a_stall_full, in_stall_o,
                   s0_valid_q && s1_valid_q && out_valid_q)
  // A beat leaving the middle stage always lands in the result register.
  `GABC_ASSERT_NEXT(a_s1_moves, s1_valid_q && adv_out, out_valid_q)

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for glyph_alpha_blend_clip: random pixel beats are blended and clipped
// by an in-bench predictor and compared with the block's results. Depends on gabc_pkg and the RTL.
`timescale 1ns / 1ps

module tb;
  import gabc_pkg::*;

  // Divisor and rounding term of the per-channel blend, as signed integers.
  localparam int ChanMax     = 255;
  localparam int ChanRound   = 127;
  localparam int MaxReported = 10;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic             in_stall_o;
  pix_in_t          in_data_i   = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  pix_out_t         out_data_o;
  logic             psel        = 1'b0;
  logic             penable     = 1'b0;
  logic             pwrite      = 1'b0;
  logic [AddrW-1:0] paddr       = '0;
  logic [DataW-1:0] pwdata      = '0;
  logic [DataW-1:0] prdata;
  logic             pready;

  // Copy of the six configuration registers, held as plain integers.
  int cfg_left  = 0;
  int cfg_top   = 0;
  int cfg_right = 0;
  int cfg_bot   = 0;
  int cfg_fb_w  = 0;
  int cfg_fb_h  = 0;

  // Pixels waiting to be offered, and the results the block owes us, oldest first.
  pix_in_t  pixel_pending_q[$];
  pix_out_t blend_expect_q[$];

  // Idle control: the sender gaps and the receiver stalls only when their mode bit is set.
  // hold_off is the long receiver hold-off that fills the pipeline.
  logic gap_mode   = 1'b0;
  logic stall_mode = 1'b0;
  logic hold_off   = 1'b0;

  int mismatch_cnt = 0;

  glyph_alpha_blend_clip uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #10 clk_i = ~clk_i;

  // The effective drawing window is the clip rectangle cut down to the framebuffer.
  function automatic void clip_span(output int lo_x, output int hi_x,
                                    output int lo_y, output int hi_y);
    lo_x = (cfg_left < 0) ? 0 : cfg_left;
    lo_y = (cfg_top < 0) ? 0 : cfg_top;
    hi_x = (cfg_right > cfg_fb_w) ? cfg_fb_w : cfg_right;
    hi_y = (cfg_bot > cfg_fb_h) ? cfg_fb_h : cfg_bot;
  endfunction

  // Expected result of one pixel under the current registers. Signed int division truncates
  // toward zero, which matches the blend's rounding on negative differences.
  function automatic pix_out_t predict_blend(pix_in_t p);
    pix_out_t   r;
    int         lo_x, hi_x, lo_y, hi_y;
    int         x, y, t, ca, cb, c;
    logic [23:0] rgb;
    r = '0;
    clip_span(lo_x, hi_x, lo_y, hi_y);
    x = int'($signed(p.pixel_x));
    y = int'($signed(p.pixel_y));
    if (x >= lo_x && x < hi_x && y >= lo_y && y < hi_y && p.coverage != CovNone) begin
      if (p.coverage == CovFull) begin
        rgb = p.ink_rgb;
      end else begin
        t = int'(p.coverage);
        for (int k = 0; k < 3; k++) begin
          ca = int'(p.dest_rgb[8*k +: 8]);
          cb = int'(p.ink_rgb[8*k +: 8]);
          c  = ca + ((cb - ca) * t + ChanRound) / ChanMax;
          if (c < 0) c = 0;
          if (c > ChanMax) c = ChanMax;
          rgb[8*k +: 8] = c[7:0];
        end
      end
      r.write_enable = 1'b1;
      r.pixel_out    = {AlphaOut, rgb};
    end
    return r;
  endfunction

  // Pick a position near the drawing window most of the time, so that both sides of every
  // edge are hit often; the rest are anywhere in the 16-bit space.
  function automatic pix_in_t random_pixel();
    pix_in_t p;
    int      lo_x, hi_x, lo_y, hi_y, span_x, span_y, pick;
    clip_span(lo_x, hi_x, lo_y, hi_y);
    span_x = (hi_x > lo_x) ? hi_x - lo_x : 4;
    span_y = (hi_y > lo_y) ? hi_y - lo_y : 4;
    if ($urandom_range(0, 99) < 80) begin
      p.pixel_x = 16'(lo_x + int'($urandom_range(0, span_x + 3)) - 2);
      p.pixel_y = 16'(lo_y + int'($urandom_range(0, span_y + 3)) - 2);
    end else begin
      p.pixel_x = 16'($urandom);
      p.pixel_y = 16'($urandom);
    end
    pick = $urandom_range(0, 99);
    if (pick < 12) p.coverage = CovNone;
    else if (pick < 27) p.coverage = CovFull;
    else p.coverage = 8'($urandom);
    pick = $urandom_range(0, 9);
    p.dest_rgb = (pick == 0) ? 24'h000000 : (pick == 1) ? 24'hffffff : 24'($urandom);
    pick = $urandom_range(0, 9);
    p.ink_rgb  = (pick == 0) ? 24'h000000 : (pick == 1) ? 24'hffffff : 24'($urandom);
    return p;
  endfunction

  task automatic queue_pixel(int x, int y, int cov, logic [23:0] dest, logic [23:0] ink);
    pix_in_t p;
    p.pixel_x  = 16'(x);
    p.pixel_y  = 16'(y);
    p.coverage = 8'(cov);
    p.dest_rgb = dest;
    p.ink_rgb  = ink;
    pixel_pending_q.push_back(p);
  endtask

  task automatic queue_random(int n);
    repeat (n) pixel_pending_q.push_back(random_pixel());
  endtask

  // One APB write: setup cycle, then access cycle held until pready. The register takes the
  // value at the edge that ends the access, so the predictor's copy is updated right after it.
  task automatic apb_write(reg_idx_e idx, int value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'({idx, 2'b00});
    pwdata  <= DataW'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      RegClipLeft:   cfg_left  = int'($signed(value[15:0]));
      RegClipTop:    cfg_top   = int'($signed(value[15:0]));
      RegClipRight:  cfg_right = int'($signed(value[15:0]));
      RegClipBottom: cfg_bot   = int'($signed(value[15:0]));
      RegFbWidth:    cfg_fb_w  = int'(value[13:0]);
      RegFbHeight:   cfg_fb_h  = int'(value[13:0]);
      default: ;
    endcase
  endtask

  task automatic configure(int l, int t, int r, int b, int w, int h);
    apb_write(RegClipLeft, l);
    apb_write(RegClipTop, t);
    apb_write(RegClipRight, r);
    apb_write(RegClipBottom, b);
    apb_write(RegFbWidth, w);
    apb_write(RegFbHeight, h);
  endtask

  // Wait until every queued pixel has been taken and every result has come back. Each pixel
  // yields exactly one result, so an empty expectation queue means the pipeline is empty.
  task automatic drain();
    while (pixel_pending_q.size() != 0 || in_valid_i || blend_expect_q.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_idling(logic on);
    @(posedge clk_i);
    gap_mode   <= on;
    stall_mode <= on;
  endtask

  // Driver. A beat is accepted at an edge where valid is high and stall is low; its prediction
  // is queued right there, with the registers as they stand. After acceptance it may idle for a
  // random gap, otherwise the next pending pixel goes out on the same edge. A stalled beat is
  // held unchanged, and valid never looks at stall.
  always @(posedge clk_i) begin : pixel_driver
    logic    nxt_valid;
    pix_in_t nxt_data;
    int      gap_left;
    int      pick;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      gap_left = 0;
    end else begin
      nxt_valid = in_valid_i;
      nxt_data  = in_data_i;
      if (in_valid_i && !in_stall_o) begin
        blend_expect_q.push_back(predict_blend(in_data_i));
        void'(pixel_pending_q.pop_front());
        nxt_valid = 1'b0;
        pick = $urandom_range(0, 99);
        if (!gap_mode || pick < 65) gap_left = 0;
        else if (pick < 95) gap_left = $urandom_range(1, 3);
        else gap_left = $urandom_range(8, 40);
      end
      if (!nxt_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pixel_pending_q.size() != 0) begin
          nxt_valid = 1'b1;
          nxt_data  = pixel_pending_q[0];
        end
      end
      in_valid_i <= nxt_valid;
      in_data_i  <= nxt_data;
    end
  end

  // Monitor. Every accepted result is checked field by field against the oldest prediction.
  // The stall it drives for the next cycle mixes short random bursts, a few long ones, and the
  // long hold-off from the stimulus process.
  always @(posedge clk_i) begin : result_monitor
    pix_out_t exp_beat;
    int       stall_left;
    int       pick;
    logic     nxt_stall;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (blend_expect_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MaxReported)
            $display("%0t: result beat with nothing expected: we=%0b px=%08h", $realtime,
                     out_data_o.write_enable, out_data_o.pixel_out);
        end else begin
          exp_beat = blend_expect_q.pop_front();
          if (out_data_o.write_enable !== exp_beat.write_enable ||
              out_data_o.pixel_out !== exp_beat.pixel_out) begin
            mismatch_cnt++;
            if (mismatch_cnt <= MaxReported)
              $display("%0t: mismatch: expected we=%0b px=%08h, got we=%0b px=%08h",
                       $realtime, exp_beat.write_enable, exp_beat.pixel_out,
                       out_data_o.write_enable, out_data_o.pixel_out);
          end
        end
      end
      nxt_stall = 1'b0;
      if (stall_left > 0) begin
        stall_left--;
        nxt_stall = 1'b1;
      end else if (stall_mode) begin
        pick = $urandom_range(0, 99);
        if (pick >= 75) begin
          nxt_stall  = 1'b1;
          stall_left = (pick >= 97) ? $urandom_range(15, 40) : $urandom_range(0, 2);
        end
      end
      out_stall_i <= nxt_stall | hold_off;
    end
  end

  // Stimulus: reset, then phases of register settings, each with its pixels; the registers are
  // only rewritten once the previous phase has fully drained.
  initial begin : stimulus
    int l, t, w, h;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Out of reset every register is zero, so the window is empty and nothing is written.
    queue_pixel(0, 0, 255, 24'h000000, 24'hffffff);
    queue_pixel(0, 0, 128, 24'h102030, 24'hf0e0d0);
    queue_pixel(-1, -1, 1, 24'hffffff, 24'h000000);
    drain();

    // A window well inside the framebuffer: both sides of each edge, coverage extremes and the
    // blend at its steepest in both directions.
    configure(10, 5, 100, 80, 640, 480);
    queue_pixel(10, 5, 255, 24'h000000, 24'hffffff);
    queue_pixel(99, 79, 1, 24'hffffff, 24'h000000);
    queue_pixel(9, 5, 200, 24'h123456, 24'h654321);
    queue_pixel(100, 5, 200, 24'h123456, 24'h654321);
    queue_pixel(10, 4, 200, 24'h123456, 24'h654321);
    queue_pixel(10, 80, 200, 24'h123456, 24'h654321);
    queue_pixel(50, 40, 0, 24'hffffff, 24'hffffff);
    queue_pixel(50, 40, 128, 24'h000000, 24'hffffff);
    queue_pixel(50, 40, 254, 24'hffffff, 24'h000000);
    queue_pixel(50, 40, 127, 24'h123456, 24'hfedcba);
    queue_pixel(50, 40, 64, 24'h00ff00, 24'hff00ff);
    queue_pixel(-32768, -32768, 255, 24'hffffff, 24'hffffff);
    queue_pixel(32767, 32767, 255, 24'hffffff, 24'hffffff);
    drain();
    set_idling(1'b1);
    queue_random(200);
    drain();

    // Register extremes: the widest clip and the largest framebuffer, run without any idling.
    configure(-32768, -32768, 32767, 32767, 16383, 16383);
    set_idling(1'b0);
    queue_random(200);
    drain();

    // A clip far larger than a small framebuffer. The receiver holds off for a long stretch
    // while the driver keeps offering, so the pipeline fills and the input stalls.
    configure(-5, -5, 32767, 32767, 37, 21);
    set_idling(1'b1);
    queue_random(200);
    repeat (20) @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (300) @(posedge clk_i);
    hold_off <= 1'b0;
    drain();

    // Empty clip: right edge equal to the left edge.
    configure(50, 50, 50, 60, 640, 480);
    queue_random(60);
    drain();

    // Zero framebuffer width, then zero height; both leave nothing to draw.
    configure(0, 0, 100, 100, 0, 100);
    queue_random(40);
    drain();
    configure(0, 0, 100, 100, 100, 0);
    queue_random(40);
    drain();

    // Random settings, some of them with an empty window or the largest framebuffer.
    repeat (4) begin
      l = int'($urandom_range(0, 100)) - 20;
      t = int'($urandom_range(0, 100)) - 20;
      w = ($urandom_range(0, 9) == 0) ? 16383 : int'($urandom_range(0, 300));
      h = ($urandom_range(0, 9) == 0) ? 16383 : int'($urandom_range(0, 300));
      configure(l, t, l + int'($urandom_range(0, 200)) - 10,
                t + int'($urandom_range(0, 200)) - 10, w, h);
      queue_random(180);
      drain();
    end

    // Any result beyond the last expected one would show up as unexpected here.
    repeat (10) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #(20_000_000);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
